### sv/mnp_pkg.sv
// Shared types, constants and command/status bundles for the MIDI note pairing block.
package mnp_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int PEND_IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);
  localparam int TICK_W     = 32;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 88;

  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_NOTE  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MATCH,
    ST_WAIT_NOTE,
    ST_WAIT_LAST
  } state_t;

  typedef struct packed {
    logic [3:0]        chan;
    logic [6:0]        key;
    logic [6:0]        vel;
    logic [TICK_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic  latch;     // capture the input request
    logic  scan;      // register the oldest-match vector
    logic  store;     // append a new pending note
    logic  load_ev;   // load the event itself into the output register
    kind_t ev_kind;
    logic  load_note; // load the completed note and drop its entry
  } cmd_t;

  typedef struct packed {
    logic is_on;
    logic is_off;
    logic full;
    logic any_match;
    logic out_take;
  } sts_t;

endpackage

### sv/mnp_ctrl.sv
// Controller state machine for the MIDI note pairing block.
module mnp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mnp_pkg::sts_t sts,
  output mnp_pkg::cmd_t cmd
);

  mnp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mnp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mnp_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = mnp_pkg::ST_CLASS;
      end
      mnp_pkg::ST_CLASS: begin
        if (sts.is_on && !sts.full) state_nxt = mnp_pkg::ST_IDLE;
        else if (sts.is_off)        state_nxt = mnp_pkg::ST_MATCH;
        else                        state_nxt = mnp_pkg::ST_WAIT_LAST;
      end
      mnp_pkg::ST_MATCH: begin
        state_nxt = sts.any_match ? mnp_pkg::ST_WAIT_NOTE : mnp_pkg::ST_IDLE;
      end
      mnp_pkg::ST_WAIT_NOTE: begin
        if (sts.out_take) state_nxt = mnp_pkg::ST_WAIT_LAST;
      end
      mnp_pkg::ST_WAIT_LAST: begin
        if (sts.out_take) state_nxt = mnp_pkg::ST_IDLE;
      end
      default: state_nxt = mnp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.ev_kind   = mnp_pkg::KIND_PASS;
    unique case (state_r)
      mnp_pkg::ST_IDLE: begin
        // take nothing while reset is held
        in_tready = rst_n;
        cmd.latch = in_tvalid && rst_n;
      end
      mnp_pkg::ST_CLASS: begin
        cmd.scan = 1'b1;
        if (sts.is_on) begin
          cmd.store   = !sts.full;
          cmd.load_ev = sts.full;
          cmd.ev_kind = mnp_pkg::KIND_FULL;
        end else if (!sts.is_off) begin
          cmd.load_ev = 1'b1;
          cmd.ev_kind = mnp_pkg::KIND_PASS;
        end
      end
      mnp_pkg::ST_MATCH: begin
        cmd.load_note = sts.any_match;
      end
      mnp_pkg::ST_WAIT_NOTE: begin
        // reload the output register with the closing event as the note leaves
        cmd.load_ev = sts.out_take;
        cmd.ev_kind = mnp_pkg::KIND_CLOSE;
      end
      mnp_pkg::ST_WAIT_LAST: begin
        cmd.load_ev = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### sv/mnp_dpath.sv
// Datapath: event register, oldest-first pending table, match search and output register.
module mnp_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mnp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mnp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  mnp_pkg::cmd_t                    cmd,
  output mnp_pkg::sts_t                    sts
);

  localparam int D = mnp_pkg::PEND_DEPTH;

  // captured event
  logic [7:0]                ev_st_r;
  logic [6:0]                ev_d1_r;
  logic [6:0]                ev_d2_r;
  logic [mnp_pkg::TICK_W-1:0] ev_tick_r;

  // pending table
  mnp_pkg::entry_t               ent_r [D];
  mnp_pkg::entry_t               ent_nxt [D];
  logic [D-1:0]                  vld_r, vld_nxt;
  logic [mnp_pkg::PEND_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [D-1:0]    match, first_hot, first_hot_r, at_or_after;
  mnp_pkg::entry_t sel_ent, new_ent;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  mnp_pkg::kind_t             out_kind_r;
  logic [7:0]                 out_st_r;
  logic [6:0]                 out_d1_r;
  logic [6:0]                 out_d2_r;
  logic [mnp_pkg::TICK_W-1:0] out_t0_r;
  logic [mnp_pkg::TICK_W-1:0] out_t1_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ev_st_r   <= in_tdata[7:0];
      ev_d1_r   <= in_tdata[14:8];
      ev_d2_r   <= in_tdata[21:15];
      ev_tick_r <= in_tdata[22 +: mnp_pkg::TICK_W];
    end
  end

  always_comb begin
    sts.is_on  = (ev_st_r[7:4] == mnp_pkg::MIDI_NOTE_ON) && (ev_d2_r != 7'd0);
    sts.is_off = (ev_st_r[7:4] == mnp_pkg::MIDI_NOTE_OFF) ||
                 ((ev_st_r[7:4] == mnp_pkg::MIDI_NOTE_ON) && (ev_d2_r == 7'd0));
    sts.full   = (cnt_r == mnp_pkg::PEND_CNT_W'(D));
    sts.any_match = |first_hot_r;
    sts.out_take  = out_valid_r && out_tready;
  end

  // compare every entry at once, keep the lowest (oldest) hit
  always_comb begin
    for (int i = 0; i < D; i++) begin
      match[i] = vld_r[i] && (ent_r[i].key == ev_d1_r) && (ent_r[i].chan == ev_st_r[3:0]);
    end
    first_hot   = match & (~match + D'(1));
    at_or_after = ~(first_hot_r - D'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) first_hot_r <= first_hot;
  end

  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < D; i++) begin
      if (first_hot_r[i]) sel_ent = ent_r[i];
    end
    new_ent.chan  = ev_st_r[3:0];
    new_ent.key   = ev_d1_r;
    new_ent.vel   = ev_d2_r;
    new_ent.start = ev_tick_r;
  end

  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    if (cmd.store) begin
      ent_nxt[cnt_r[mnp_pkg::PEND_IDX_W-1:0]] = new_ent;
      vld_nxt[cnt_r[mnp_pkg::PEND_IDX_W-1:0]] = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.load_note) begin
      // close the gap: every entry from the hit onward moves down one place
      for (int i = 0; i < D - 1; i++) begin
        if (at_or_after[i]) begin
          ent_nxt[i] = ent_r[i+1];
          vld_nxt[i] = vld_r[i+1];
        end
      end
      vld_nxt[D-1] = 1'b0;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_ev || cmd.load_note) out_valid_nxt = 1'b1;
    else if (out_tready)              out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_note) begin
      out_kind_r <= mnp_pkg::KIND_NOTE;
      out_st_r   <= {mnp_pkg::MIDI_NOTE_ON, sel_ent.chan};
      out_d1_r   <= sel_ent.key;
      out_d2_r   <= sel_ent.vel;
      out_t0_r   <= sel_ent.start;
      out_t1_r   <= ev_tick_r;
      out_last_r <= 1'b0;
    end else if (cmd.load_ev) begin
      out_kind_r <= cmd.ev_kind;
      out_st_r   <= ev_st_r;
      out_d1_r   <= ev_d1_r;
      out_d2_r   <= ev_d2_r;
      out_t0_r   <= ev_tick_r;
      out_t1_r   <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_t1_r, out_t0_r, out_d2_r, out_d1_r, out_st_r};

endmodule

### sv/midi_note_pairing_top.sv
// Top level of the MIDI note on/off pairing block: controller plus datapath.
// out_tvalid is raised by the output register load in ST_CLASS for a passthrough or table-full
// request, and by the load in ST_MATCH, after ST_CLASS, for the completed note of a matched off;
// the closing event is loaded into the output register at the edge on which the note is taken.
// An unmatched off gives no result. A new request is accepted only back in ST_IDLE, once every
// result of the last one has been taken. Reset (rst_n low, synchronous) empties the pending
// table and the output register and holds in_tready low.
module midi_note_pairing_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mnp_pkg::IN_TDATA_W-1:0]   in_tdata,   // status_byte, data_one, data_two,
                                                       // tick_time, 2 bits zero pad
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mnp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_status, out_data_one,
                                                       // out_data_two, start_tick, end_tick,
                                                       // 2 bits zero pad
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast   // last_result
);

  // command and status between controller and datapath
  mnp_pkg::cmd_t cmd;
  mnp_pkg::sts_t sts;

  // controller: accept a request only when idle, then step through classify,
  // match and the output hand-off
  mnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: hold the request, search the pending table oldest first,
  // drop the matched entry and drive the output register
  mnp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
